### rtl/fbfl_pkg.sv
// Shared types, codes and helpers for the fixed block free list allocator.
// No dependencies; imported by every module of the block.
package fbfl_pkg;

  localparam int BLOCK_W = 8;
  localparam int COUNT_W = 9;
  localparam int TOTAL_W = 32;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Limit a written pool size to 1 .. lim.
  function automatic logic [COUNT_W-1:0] clamp_pool(input logic [COUNT_W-1:0] val,
                                                    input logic [COUNT_W-1:0] lim);
    logic [COUNT_W-1:0] res;
    res = val;
    if (val == '0) res = COUNT_W'(1);
    if (val > lim) res = lim;
    return res;
  endfunction

endpackage

### rtl/fbfl_link_mem.sv
// Link memory of the free list: one next-block number per block.
// Synchronous, one write and one registered read port; uses fbfl_pkg.
module fbfl_link_mem
  import fbfl_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [BLOCK_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [BLOCK_W-1:0] wr_data
);

  logic [BLOCK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed block free list allocator: request control,
// list registers, counters and result register; uses fbfl_pkg, fbfl_link_mem.
//
// channel  direction  handshake               payload
// in       to block   in_valid / in_stall     req_type, block_index
// out      from block out_valid / out_stall   status, granted_block, free_blocks,
//                                             alloc_total, free_total
// cfg      to block   cfg_valid / cfg_ready   cfg_data (pool_blocks)
//
// Each request first reads the link of the list head from the link memory,
// then updates the list and loads the result register in S_EXEC.
// A request waits in S_EXEC while the result register is full and stalled.
// Synchronous reset empties the list and sets the pool to its largest size;
// a configuration write also empties the list, but sets the pool to cfg_data clamped to 1 .. largest size.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [BLOCK_W-1:0] block_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [BLOCK_W-1:0] granted_block,
  output logic [COUNT_W-1:0] free_blocks,
  output logic [TOTAL_W-1:0] alloc_total,
  output logic [TOTAL_W-1:0] free_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int LINK_DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int AW = $clog2(LINK_DEPTH);
  localparam logic [COUNT_W-1:0] POOL_LIM = COUNT_W'(LINK_DEPTH);

  state_t             state;
  logic               req_q;
  logic [BLOCK_W-1:0] idx_q;
  logic [COUNT_W-1:0] pool_n;
  logic [BLOCK_W-1:0] list_head;
  logic               list_nonempty;
  logic [COUNT_W-1:0] fresh_next;
  logic [COUNT_W-1:0] free_count;
  logic [TOTAL_W-1:0] alloc_count;
  logic [TOTAL_W-1:0] dealloc_count;

  logic               in_xfer;
  logic               commit;
  logic [BLOCK_W-1:0] link_rd;
  logic               link_wr_en;
  logic [BLOCK_W-1:0] link_wr_data;

  logic [1:0]         status_next;
  logic [BLOCK_W-1:0] granted_next;
  logic [BLOCK_W-1:0] head_next;
  logic               nonempty_next;
  logic [COUNT_W-1:0] fresh_next_next;
  logic [COUNT_W-1:0] free_count_next;
  logic [TOTAL_W-1:0] alloc_count_next;
  logic [TOTAL_W-1:0] dealloc_count_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign commit    = (state == S_EXEC) && (!out_valid || !out_stall);

  fbfl_link_mem #(
    .DEPTH (LINK_DEPTH),
    .AW    (AW)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (list_head[AW-1:0]),
    .rd_data (link_rd),
    .wr_en   (link_wr_en),
    .wr_addr (idx_q[AW-1:0]),
    .wr_data (link_wr_data)
  );

  always_comb begin
    status_next        = ST_OK;
    granted_next       = '0;
    head_next          = list_head;
    nonempty_next      = list_nonempty;
    fresh_next_next    = fresh_next;
    free_count_next    = free_count;
    alloc_count_next   = alloc_count;
    dealloc_count_next = dealloc_count;
    link_wr_en         = 1'b0;
    link_wr_data       = list_nonempty ? list_head : idx_q;
    unique case (req_q)
      REQ_ALLOC: begin
        priority if (list_nonempty) begin
          granted_next = list_head;
          if (link_rd == list_head) begin
            nonempty_next = 1'b0;
          end else begin
            head_next = link_rd;
          end
        end else if (fresh_next < pool_n) begin
          granted_next    = fresh_next[BLOCK_W-1:0];
          fresh_next_next = fresh_next + COUNT_W'(1);
        end else begin
          status_next = ST_EMPTY;
        end
        if (status_next == ST_OK) begin
          if (free_count != '0) free_count_next = free_count - COUNT_W'(1);
          alloc_count_next = alloc_count + TOTAL_W'(1);
        end
      end
      REQ_FREE: begin
        if ({1'b0, idx_q} >= pool_n) begin
          status_next = ST_RANGE;
        end else begin
          link_wr_en    = commit;
          head_next     = idx_q;
          nonempty_next = 1'b1;
          if (free_count < pool_n) free_count_next = free_count + COUNT_W'(1);
          dealloc_count_next = dealloc_count + TOTAL_W'(1);
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      pool_n        <= POOL_LIM;
      list_head     <= '0;
      list_nonempty <= 1'b0;
      fresh_next    <= '0;
      free_count    <= POOL_LIM;
      alloc_count   <= '0;
      dealloc_count <= '0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pool_n        <= clamp_pool(cfg_data, POOL_LIM);
        list_head     <= '0;
        list_nonempty <= 1'b0;
        fresh_next    <= '0;
        free_count    <= clamp_pool(cfg_data, POOL_LIM);
        alloc_count   <= '0;
        dealloc_count <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) state <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            state         <= S_IDLE;
            list_head     <= head_next;
            list_nonempty <= nonempty_next;
            fresh_next    <= fresh_next_next;
            free_count    <= free_count_next;
            alloc_count   <= alloc_count_next;
            dealloc_count <= dealloc_count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the request and load the result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q <= req_type;
      idx_q <= block_index;
    end
    if (commit) begin
      status        <= status_next;
      granted_block <= granted_next;
      free_blocks   <= free_count_next;
      alloc_total   <= alloc_count_next;
      free_total    <= dealloc_count_next;
    end
  end

endmodule

### test/testbench.sv
// Self-checking testbench for fixed_block_free_list_allocator: allocate and free requests
// are checked against an in-bench free list predictor, across several pool sizes.
// Depends on fbfl_pkg and the allocator RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [BLOCK_W-1:0] grant;
    logic [COUNT_W-1:0] free_n;
    logic [TOTAL_W-1:0] allocs;
    logic [TOTAL_W-1:0] frees;
  } reply_t;

  localparam int POOL_MAX       = 256;
  localparam int IDLE_MAX       = 11;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_ALLOC;
  logic [BLOCK_W-1:0] block_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [BLOCK_W-1:0] granted_block;
  logic [COUNT_W-1:0] free_blocks;
  logic [TOTAL_W-1:0] alloc_total;
  logic [TOTAL_W-1:0] free_total;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // free list shadow
  logic [BLOCK_W-1:0] shadow_link [POOL_MAX];
  logic [BLOCK_W-1:0] shadow_head;
  bit                 shadow_live;
  logic [COUNT_W-1:0] shadow_fresh;
  logic [COUNT_W-1:0] shadow_free;
  logic [COUNT_W-1:0] shadow_pool;
  logic [TOTAL_W-1:0] shadow_allocs;
  logic [TOTAL_W-1:0] shadow_frees;

  reply_t             due_replies [$];
  logic [BLOCK_W-1:0] held_blocks [$];
  int unsigned        mismatches;
  int unsigned        sent_count;
  int unsigned        seen_count;
  int unsigned        cfg_count;
  int unsigned        status_seen [3];
  int unsigned        idle_cycles;
  bit                 quiet;

  fixed_block_free_list_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .block_index  (block_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_block(granted_block),
    .free_blocks  (free_blocks),
    .alloc_total  (alloc_total),
    .free_total   (free_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COUNT_W-1:0] effective_pool(input logic [COUNT_W-1:0] v);
    if (v == '0) return COUNT_W'(1);
    if (v > POOL_MAX) return COUNT_W'(POOL_MAX);
    return v;
  endfunction

  task automatic reinit_pool(input logic [COUNT_W-1:0] v);
    shadow_pool   = effective_pool(v);
    shadow_live   = 1'b0;
    shadow_head   = '0;
    shadow_fresh  = '0;
    shadow_free   = shadow_pool;
    shadow_allocs = '0;
    shadow_frees  = '0;
    held_blocks.delete();
  endtask

  task automatic pool_step(input logic req, input logic [BLOCK_W-1:0] idx, output reply_t r);
    r = '0;
    r.status = ST_OK;
    if (req == REQ_ALLOC) begin
      if (shadow_live) begin
        r.grant = shadow_head;
        if (shadow_link[shadow_head] == shadow_head) shadow_live = 1'b0;
        else shadow_head = shadow_link[shadow_head];
      end else if (shadow_fresh < shadow_pool) begin
        r.grant = shadow_fresh[BLOCK_W-1:0];
        shadow_fresh++;
      end else begin
        r.status = ST_EMPTY;
      end
      if (r.status == ST_OK) begin
        if (shadow_free != '0) shadow_free--;
        shadow_allocs++;
      end
    end else if (COUNT_W'(idx) >= shadow_pool) begin
      r.status = ST_RANGE;
    end else begin
      shadow_link[idx] = shadow_live ? shadow_head : idx;
      shadow_head = idx;
      shadow_live = 1'b1;
      if (shadow_free < shadow_pool) shadow_free++;
      shadow_frees++;
    end
    r.free_n = shadow_free;
    r.allocs = shadow_allocs;
    r.frees  = shadow_frees;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_req(input logic req, input logic [BLOCK_W-1:0] idx);
    int     gap;
    reply_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, IDLE_MAX);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    block_index <= idx;
    do @(posedge clk); while (in_stall);
    pool_step(req, idx, r);
    due_replies.push_back(r);
    if (req == REQ_ALLOC && r.status == ST_OK) held_blocks.push_back(r.grant);
    sent_count++;
  endtask

  // hold the sender until every result has come back
  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_replies.size() != 0);
  endtask

  task automatic write_pool(input logic [COUNT_W-1:0] v);
    drain_requests();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reinit_pool(v);
    cfg_count++;
  endtask

  task automatic random_item(input int alloc_pct);
    int                 pick;
    int                 slot;
    logic [BLOCK_W-1:0] idx;
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_req(REQ_ALLOC, BLOCK_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 75 && held_blocks.size() != 0) begin
        slot = $urandom_range(0, held_blocks.size() - 1);
        idx = held_blocks[slot];
        held_blocks.delete(slot);
      end else if (pick < 88) begin
        idx = BLOCK_W'($urandom_range(0, shadow_pool - 1));
      end else begin
        idx = BLOCK_W'($urandom);
      end
      send_req(REQ_FREE, idx);
    end
  endtask

  task automatic test_reset_state();
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'hFF);
    send_req(REQ_FREE, 8'hFF);
    send_req(REQ_FREE, 8'h00);
    send_req(REQ_ALLOC, 8'h5A);
    send_req(REQ_ALLOC, 8'hA5);
    send_req(REQ_ALLOC, 8'h00);
  endtask

  task automatic test_single_block_pool();
    write_pool(9'd0);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'hFF);
    send_req(REQ_FREE, 8'h01);
    send_req(REQ_FREE, 8'hFF);
    send_req(REQ_FREE, 8'h00);
    send_req(REQ_FREE, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
  endtask

  task automatic test_clamped_pool();
    write_pool(9'h1FF);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_FREE, 8'h00);
    send_req(REQ_FREE, 8'h01);
    send_req(REQ_FREE, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_FREE, 8'hAA);
  endtask

  task automatic test_fill_and_empty();
    int slot;
    write_pool(9'd256);
    repeat (POOL_MAX + 1) send_req(REQ_ALLOC, BLOCK_W'($urandom));
    while (held_blocks.size() != 0) begin
      slot = $urandom_range(0, held_blocks.size() - 1);
      send_req(REQ_FREE, held_blocks[slot]);
      held_blocks.delete(slot);
    end
    send_req(REQ_ALLOC, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] sizes [8];
    int                 bias;
    sizes = '{9'd2, 9'd3, 9'd17, 9'd256, 9'd1, 9'd100, 9'd300,
              COUNT_W'($urandom_range(1, 511))};
    foreach (sizes[p]) begin
      if (p == 7) quiet = 1'b1;
      write_pool(sizes[p]);
      for (int n = 0; n < 150; n++) begin
        if (n % 30 == 0) bias = $urandom_range(0, 2) * 35 + 15;
        if (n == 75) drain_requests();
        random_item(bias);
      end
    end
  endtask

  initial begin : stall_bursts
    int span;
    forever begin
      span = $urandom_range(1, IDLE_MAX);
      out_stall <= (!quiet && $urandom_range(0, 2) == 0);
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      seen_count++;
      if (due_replies.size() == 0) begin
        report_mismatch("result with nothing outstanding, status", 32'(status), '0);
      end else begin
        want = due_replies.pop_front();
        if (status != want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (granted_block != want.grant)
          report_mismatch("granted_block", 32'(granted_block), 32'(want.grant));
        if (free_blocks != want.free_n)
          report_mismatch("free_blocks", 32'(free_blocks), 32'(want.free_n));
        if (alloc_total != want.allocs) report_mismatch("alloc_total", alloc_total, want.allocs);
        if (free_total != want.frees) report_mismatch("free_total", free_total, want.frees);
        if (want.status <= ST_RANGE) status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    reinit_pool(9'd256);
    test_reset_state();
    test_single_block_pool();
    test_clamped_pool();
    test_fill_and_empty();
    test_random_traffic();
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d pool size writes",
             sent_count, seen_count, cfg_count);
    $display("outcomes: %0d granted or freed, %0d pool empty, %0d index out of range",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE]);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### fixed_block_free_list_allocator.f
rtl/fbfl_pkg.sv
rtl/fbfl_link_mem.sv
rtl/fixed_block_free_list_allocator.sv
test/testbench.sv
